@@ sv/kcl_pkg.sv @@
// Shared types and constants for the keypad code lock controller.
`default_nettype none
package kcl_pkg;

  // Bytes of a code that are kept and compared; one more byte closes an entry
  localparam int CODE_BYTES = 4;
  localparam int CODE_W     = 8 * CODE_BYTES;
  localparam int IDX_W      = $clog2(CODE_BYTES + 1);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_MOTOR_TICKS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_TICKS = 2'd1;
  localparam logic [1:0] CFG_MAX_FAILS   = 2'd2;

  localparam logic [15:0] MOTOR_TICKS_RST = 16'd7500;
  localparam logic [15:0] BLOCK_TICKS_RST = 16'd40000;
  localparam logic [2:0]  MAX_FAILS_RST   = 3'd3;

  // Message codes
  localparam logic [3:0] MSG_NONE    = 4'd0;
  localparam logic [3:0] MSG_GET     = 4'd1;
  localparam logic [3:0] MSG_OPENING = 4'd2;
  localparam logic [3:0] MSG_NEW     = 4'd3;
  localparam logic [3:0] MSG_SAVED   = 4'd4;
  localparam logic [3:0] MSG_MENU    = 4'd5;
  localparam logic [3:0] MSG_BAD     = 4'd6;
  localparam logic [3:0] MSG_WRONG   = 4'd7;
  localparam logic [3:0] MSG_WARN    = 4'd8;

  // Motor drive codes
  localparam logic [1:0] MOTOR_OFF  = 2'd0;
  localparam logic [1:0] MOTOR_CW   = 2'd1;
  localparam logic [1:0] MOTOR_ACW  = 2'd2;

  localparam logic [7:0] KEY_OPEN   = 8'h2A;  // '*'
  localparam logic [7:0] KEY_CHANGE = 8'h23;  // '#'

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] key_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0] message;
    logic [1:0] motor_drive;
    logic       buzzer_on;
    logic       led_on;
    logic       last_result;
  } out_word_t;

  // Words handed from the step logic to the result queue
  typedef struct packed {
    logic      push;
    logic      two;
    out_word_t w0;
    out_word_t w1;
  } res_push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } fifo_stat_t;

endpackage
`default_nettype wire

@@ sv/kcl_core.sv @@
// Lock state and the per-word step logic.
`default_nettype none
module kcl_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step_en,
  input  kcl_pkg::in_word_t   item,
  input  wire  [15:0]         motor_ticks,
  input  wire  [15:0]         block_ticks,
  input  wire  [2:0]          max_fails,
  output kcl_pkg::res_push_t  res
);

  localparam logic [2:0] MODE_NEW_FIRST  = 3'd0;
  localparam logic [2:0] MODE_NEW_SECOND = 3'd1;
  localparam logic [2:0] MODE_MENU       = 3'd2;
  localparam logic [2:0] MODE_CHECK      = 3'd3;
  localparam logic [2:0] MODE_MOTOR_CW   = 3'd4;
  localparam logic [2:0] MODE_MOTOR_ACW  = 3'd5;
  localparam logic [2:0] MODE_BLOCKED    = 3'd6;

  logic [2:0]                   mode_r, mode_nxt;
  logic                         purpose_r, purpose_nxt;
  logic [kcl_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [kcl_pkg::CODE_W-1:0]   entry_r, entry_nxt;
  logic [kcl_pkg::CODE_W-1:0]   first_r, first_nxt;
  logic [kcl_pkg::CODE_W-1:0]   stored_r;
  logic                         stored_we;
  logic [2:0]                   fail_r, fail_nxt;
  logic [15:0]                  tick_r, tick_nxt;
  logic [1:0]                   motor_r, motor_nxt;
  logic                         buzzer_r, buzzer_nxt;
  logic                         led_r, led_nxt;

  logic [kcl_pkg::CODE_W-1:0]   entry_taken;
  logic [kcl_pkg::IDX_W-1:0]    idx_inc;
  logic                         entry_done;
  logic [15:0]                  tick_inc;
  logic                         motor_done, block_done;
  logic [2:0]                   fail_inc;
  logic                         fail_block;
  logic [3:0]                   msg0, msg1;
  logic                         two;

  assign idx_inc     = idx_r + 1'b1;
  assign entry_done  = (idx_r == kcl_pkg::IDX_W'(kcl_pkg::CODE_BYTES));
  assign entry_taken = (idx_r < kcl_pkg::IDX_W'(kcl_pkg::CODE_BYTES)) ?
                       ((entry_r << 8) | kcl_pkg::CODE_W'(item.key_byte)) : entry_r;
  assign tick_inc    = tick_r + 16'd1;
  // a zero limit behaves as one; a wrapped counter also ends the run
  assign motor_done  = (tick_inc >= motor_ticks) || (tick_inc == 16'd0);
  assign block_done  = (tick_inc >= block_ticks) || (tick_inc == 16'd0);
  assign fail_inc    = fail_r + 3'd1;
  assign fail_block  = (fail_inc >= max_fails) || (fail_inc == 3'd0);

  always_comb begin
    mode_nxt    = mode_r;
    purpose_nxt = purpose_r;
    idx_nxt     = idx_r;
    entry_nxt   = entry_r;
    first_nxt   = first_r;
    stored_we   = 1'b0;
    fail_nxt    = fail_r;
    tick_nxt    = tick_r;
    motor_nxt   = motor_r;
    buzzer_nxt  = buzzer_r;
    led_nxt     = led_r;
    msg0        = kcl_pkg::MSG_NONE;
    msg1        = kcl_pkg::MSG_NONE;
    two         = 1'b0;
    if (step_en) begin
      if (item.action == kcl_pkg::ACT_KEY) begin
        case (mode_r)
          MODE_NEW_FIRST: begin
            entry_nxt = entry_taken;
            idx_nxt   = entry_done ? '0 : idx_inc;
            if (entry_done) begin
              first_nxt = entry_taken;
              mode_nxt  = MODE_NEW_SECOND;
              entry_nxt = '0;
            end
          end
          MODE_NEW_SECOND: begin
            entry_nxt = entry_taken;
            idx_nxt   = entry_done ? '0 : idx_inc;
            if (entry_done) begin
              entry_nxt = '0;
              if (entry_taken == first_r) begin
                stored_we = 1'b1;
                msg0      = kcl_pkg::MSG_SAVED;
                msg1      = kcl_pkg::MSG_MENU;
                two       = 1'b1;
                mode_nxt  = MODE_MENU;
              end else begin
                msg0     = kcl_pkg::MSG_NEW;
                mode_nxt = MODE_NEW_FIRST;
              end
            end
          end
          MODE_MENU: begin
            if (item.key_byte == kcl_pkg::KEY_OPEN ||
                item.key_byte == kcl_pkg::KEY_CHANGE) begin
              purpose_nxt = (item.key_byte == kcl_pkg::KEY_CHANGE);
              msg0        = kcl_pkg::MSG_GET;
              mode_nxt    = MODE_CHECK;
              idx_nxt     = '0;
              entry_nxt   = '0;
            end else begin
              msg0 = kcl_pkg::MSG_BAD;
            end
          end
          MODE_CHECK: begin
            entry_nxt = entry_taken;
            idx_nxt   = entry_done ? '0 : idx_inc;
            if (entry_done) begin
              if (entry_taken == stored_r) begin
                fail_nxt = 3'd0;
                if (purpose_r) begin
                  msg0      = kcl_pkg::MSG_NEW;
                  mode_nxt  = MODE_NEW_FIRST;
                  entry_nxt = '0;
                end else begin
                  msg0      = kcl_pkg::MSG_OPENING;
                  mode_nxt  = MODE_MOTOR_CW;
                  motor_nxt = kcl_pkg::MOTOR_CW;
                  tick_nxt  = 16'd0;
                end
              end else if (fail_block) begin
                fail_nxt   = 3'd0;
                msg0       = kcl_pkg::MSG_WARN;
                mode_nxt   = MODE_BLOCKED;
                buzzer_nxt = 1'b1;
                led_nxt    = 1'b0;
                tick_nxt   = 16'd0;
              end else begin
                fail_nxt  = fail_inc;
                msg0      = kcl_pkg::MSG_WRONG;
                msg1      = kcl_pkg::MSG_GET;
                two       = 1'b1;
                entry_nxt = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
        case (mode_r)
          MODE_MOTOR_CW: begin
            tick_nxt = motor_done ? 16'd0 : tick_inc;
            if (motor_done) begin
              motor_nxt = kcl_pkg::MOTOR_ACW;
              mode_nxt  = MODE_MOTOR_ACW;
            end
          end
          MODE_MOTOR_ACW: begin
            tick_nxt = motor_done ? 16'd0 : tick_inc;
            if (motor_done) begin
              motor_nxt = kcl_pkg::MOTOR_OFF;
              msg0      = kcl_pkg::MSG_MENU;
              mode_nxt  = MODE_MENU;
              idx_nxt   = '0;
              entry_nxt = '0;
            end
          end
          MODE_BLOCKED: begin
            tick_nxt = block_done ? 16'd0 : tick_inc;
            led_nxt  = ~led_r;
            if (block_done) begin
              buzzer_nxt = 1'b0;
              led_nxt    = 1'b0;
              msg0       = kcl_pkg::MSG_MENU;
              mode_nxt   = MODE_MENU;
              idx_nxt    = '0;
              entry_nxt  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NEW_FIRST;
      purpose_r <= 1'b0;
      idx_r     <= '0;
      entry_r   <= '0;
      first_r   <= '0;
      fail_r    <= 3'd0;
      tick_r    <= 16'd0;
      motor_r   <= kcl_pkg::MOTOR_OFF;
      buzzer_r  <= 1'b0;
      led_r     <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      purpose_r <= purpose_nxt;
      idx_r     <= idx_nxt;
      entry_r   <= entry_nxt;
      first_r   <= first_nxt;
      fail_r    <= fail_nxt;
      tick_r    <= tick_nxt;
      motor_r   <= motor_nxt;
      buzzer_r  <= buzzer_nxt;
      led_r     <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stored_we) begin
      stored_r <= entry_taken;
    end
  end

  always_comb begin
    res.push              = step_en;
    res.two               = two;
    res.w0.message        = msg0;
    res.w0.motor_drive    = motor_nxt;
    res.w0.buzzer_on      = buzzer_nxt;
    res.w0.led_on         = led_nxt;
    res.w0.last_result    = ~two;
    res.w1.message        = msg1;
    res.w1.motor_drive    = motor_nxt;
    res.w1.buzzer_on      = buzzer_nxt;
    res.w1.led_on         = led_nxt;
    res.w1.last_result    = 1'b1;
  end

endmodule
`default_nettype wire

@@ sv/kcl_out_fifo.sv @@
// Result word queue, taking one or two words a cycle and giving one while out_ready is high.
`default_nettype none
module kcl_out_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  kcl_pkg::res_push_t   res,
  output logic                 out_valid,
  input  wire                  out_ready,
  output kcl_pkg::out_word_t   out_data,
  output kcl_pkg::fifo_stat_t  stat
);

  kcl_pkg::out_word_t             mem_r [kcl_pkg::FIFO_DEPTH];
  logic [kcl_pkg::PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [kcl_pkg::PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [kcl_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [kcl_pkg::PTR_W-1:0]      wr_ptr_p1;
  logic                           pop;
  logic [kcl_pkg::CNT_W-1:0]      n_push;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign n_push    = !res.push ? kcl_pkg::CNT_W'(0) :
                     (res.two ? kcl_pkg::CNT_W'(2) : kcl_pkg::CNT_W'(1));

  assign wr_ptr_nxt = wr_ptr_r + kcl_pkg::PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + kcl_pkg::PTR_W'(pop);
  assign count_nxt  = count_r + n_push - kcl_pkg::CNT_W'(pop);

  // room for a two-word result regardless of this cycle's pop
  assign stat.count = count_r;
  assign stat.room  = (count_r <= kcl_pkg::CNT_W'(kcl_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      mem_r[wr_ptr_r] <= res.w0;
      if (res.two) begin
        mem_r[wr_ptr_p1] <= res.w1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/keypad_code_lock_controller_top.sv @@
// Keypad code lock controller: input register, configuration, step logic and result queue.
// Each input word (a keypad byte or a timer tick) is registered on acceptance and processed
// from that register once the queue has space for two words, its one or two result words
// landing in a four-word output queue whose head is presented on the output. A new input
// word is taken every cycle while the queue has space for two words, so the sustained rate
// is one input word per cycle, bounded by the output channel delivering one result word per
// cycle while out_ready is high (an input that gives two results needs two output words).
// Configuration writes are taken every cycle.
`default_nettype none
module keypad_code_lock_controller_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  kcl_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output kcl_pkg::out_word_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data
);

  logic                 pipe_valid_r;
  kcl_pkg::in_word_t    pipe_item_r;
  logic                 step_go;
  logic                 in_acc;

  logic [15:0]          motor_ticks_r;
  logic [15:0]          block_ticks_r;
  logic [2:0]           max_fails_r;

  kcl_pkg::res_push_t   res;
  kcl_pkg::fifo_stat_t  fstat;

  assign cfg_ready = 1'b1;
  assign step_go   = pipe_valid_r & fstat.room;
  assign in_ready  = ~pipe_valid_r | step_go;
  assign in_acc    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
    end else if (in_acc) begin
      pipe_valid_r <= 1'b1;
    end else if (step_go) begin
      pipe_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pipe_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_ticks_r <= kcl_pkg::MOTOR_TICKS_RST;
      block_ticks_r <= kcl_pkg::BLOCK_TICKS_RST;
      max_fails_r   <= kcl_pkg::MAX_FAILS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kcl_pkg::CFG_MOTOR_TICKS: motor_ticks_r <= cfg_data;
        kcl_pkg::CFG_BLOCK_TICKS: block_ticks_r <= cfg_data;
        kcl_pkg::CFG_MAX_FAILS:   max_fails_r   <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  kcl_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_go),
    .item        (pipe_item_r),
    .motor_ticks (motor_ticks_r),
    .block_ticks (block_ticks_r),
    .max_fails   (max_fails_r),
    .res         (res)
  );

  kcl_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (fstat)
  );

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count <= kcl_pkg::CNT_W'(kcl_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // a held word waiting for queue space is not dropped
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_valid_r && !fstat.room |=> pipe_valid_r && $stable(pipe_item_r))
    else $error("stalled input word lost");

  // a two-word result ends only on its second word
  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.push && res.two |-> !res.w0.last_result && res.w1.last_result)
    else $error("last flag wrong on two-word result");

endmodule
`default_nettype wire
